>>> rtl/char_pair_swap_table_macros.svh
// Assertion macros for the pair swap table.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CHAR_PAIR_SWAP_TABLE_MACROS_SVH
`define CHAR_PAIR_SWAP_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CPST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> rtl/cpst_pkg.sv
// Shared constants, types and helpers of the pair swap table.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package cpst_pkg;

  localparam int NUM_PAIRS = 32;
  localparam int CNT_W     = $clog2(NUM_PAIRS + 1);
  localparam int IDX_W     = $clog2(NUM_PAIRS);
  localparam int ENTRIES_W = 6;

  localparam logic [7:0] NO_PARTNER = 8'd32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
  } pair_t;

  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    pair_t            wr_data;
  } cell_ctrl_t;

  typedef struct packed {
    logic             scanning;
    logic [CNT_W-1:0] count;
  } status_t;

  // The reported count is the stored count kept to its low six bits.
  function automatic logic [ENTRIES_W-1:0] to_entries(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+ENTRIES_W-1:0] ext;
    ext = {{ENTRIES_W{1'b0}}, cnt};
    return ext[ENTRIES_W-1:0];
  endfunction

endpackage

>>> rtl/cpst_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on cpst_pkg for the count width.
interface cpst_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] key_a;
  logic [7:0] key_b;

  modport source (output valid, output cmd, output key_a, output key_b, input ready);
  modport sink   (input valid, input cmd, input key_a, input key_b, output ready);
endinterface

interface cpst_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    partner;
  logic                          found;
  logic                          full_error;
  logic [cpst_pkg::ENTRIES_W-1:0] entries_in_use;

  modport source (output valid, output partner, output found, output full_error,
                  output entries_in_use, input ready);
  modport sink   (input valid, input partner, input found, input full_error,
                  input entries_in_use, output ready);
endinterface

>>> rtl/char_pair_swap_table.sv
// Channel    | Dir | Payload                                      | Accepted when
// in_i       | in  | cmd, key_a, key_b                            | valid && ready
// out_o      | out | partner, found, full_error, entries_in_use   | valid && ready
//
// Add and no-op go straight from idle to done. Remove and find rotate the stored
// pairs once through the cell chain, one pair per cycle, if the table is not empty.
// Reset empties the table at once; the cells themselves are not cleared.
// A result waits in the output register while the next command is accepted;
// only a command that finishes while that register is still full stalls.
//
// Top level: the cell chain and the sequencer. Depends on cpst_pkg, the
// channel interfaces, cpst_cell, cpst_ctrl and the assertion macros.
`include "char_pair_swap_table_macros.svh"

module char_pair_swap_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpst_in_if.sink    in_i,
  cpst_out_if.source out_o
);

  cpst_pkg::cell_ctrl_t cell_ctrl;
  cpst_pkg::status_t    status;
  cpst_pkg::pair_t      cell_data [cpst_pkg::NUM_PAIRS];

  logic [cpst_pkg::CNT_W-1:0] max_count;
  logic [cpst_pkg::CNT_W-1:0] wr_idx_ext;

  assign max_count  = cpst_pkg::CNT_W'(cpst_pkg::NUM_PAIRS);
  assign wr_idx_ext = cpst_pkg::CNT_W'(cell_ctrl.wr_idx);

  cpst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .head_i      (cell_data[0]),
    .cell_ctrl_o (cell_ctrl),
    .status_o    (status)
  );

  // Cell 0 is the head; each cell takes its upstream neighbor on a shift.
  for (genvar i = 0; i < cpst_pkg::NUM_PAIRS; i++) begin : g_cell
    cpst_pkg::pair_t next_pair;
    if (i == cpst_pkg::NUM_PAIRS - 1) begin : g_last
      assign next_pair = cell_data[i];
    end else begin : g_mid
      assign next_pair = cell_data[i+1];
    end

    cpst_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (cpst_pkg::IDX_W'(i)),
      .ctrl_i (cell_ctrl),
      .next_i (next_pair),
      .data_o (cell_data[i])
    );
  end

  `CPST_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, status.count <= max_count)
  `CPST_ASSERT_NOW(a_write_in_range, clk_i, rst_ni, cell_ctrl.wr_en, wr_idx_ext <= status.count)
  `CPST_ASSERT_NOW(a_shift_only_scan, clk_i, rst_ni, cell_ctrl.shift, status.scanning && !in_i.ready)
  `CPST_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)

endmodule

>>> rtl/cpst_cell.sv
// One storage cell of the pair chain: holds a pair, loads a broadcast write
// or takes its upstream neighbor's pair on a shift. Depends on cpst_pkg.
module cpst_cell (
  input  logic                       clk_i,
  input  logic [cpst_pkg::IDX_W-1:0] idx_i,
  input  cpst_pkg::cell_ctrl_t       ctrl_i,
  input  cpst_pkg::pair_t            next_i,
  output cpst_pkg::pair_t            data_o
);

  cpst_pkg::pair_t data_q, data_d;

  // A write aimed at this cell wins over the shift.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.wr_en && (ctrl_i.wr_idx == idx_i)) begin
      data_d = ctrl_i.wr_data;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> rtl/cpst_ctrl.sv
// Command sequencer: accepts commands, drives the cell chain through a
// rotation for remove and find, and holds the result register.
// Depends on cpst_pkg and the channel interfaces.
module cpst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cpst_in_if.sink              in_i,
  cpst_out_if.source           out_o,
  input  cpst_pkg::pair_t      head_i,
  output cpst_pkg::cell_ctrl_t cell_ctrl_o,
  output cpst_pkg::status_t    status_o
);

  cpst_pkg::state_e state_q, state_d;

  logic [cpst_pkg::CNT_W-1:0] count_q, count_d;
  logic [cpst_pkg::CNT_W-1:0] step_q, step_d;
  cpst_pkg::cmd_e             cmd_q, cmd_d;
  logic [7:0]                 key_q, key_d;
  logic [7:0]                 partner_q, partner_d;
  logic                       found_q, found_d;
  logic                       full_q, full_d;

  logic                            out_valid_q, out_valid_d;
  logic [7:0]                      out_partner_q, out_partner_d;
  logic                            out_found_q, out_found_d;
  logic                            out_full_q, out_full_d;
  logic [cpst_pkg::ENTRIES_W-1:0]  out_entries_q, out_entries_d;

  cpst_pkg::cmd_e             in_cmd;
  logic                       accept;
  logic                       out_free;
  logic                       head_match;
  logic                       drop;
  logic [cpst_pkg::CNT_W-1:0] count_m1;

  assign in_cmd     = cpst_pkg::cmd_e'(in_i.cmd);
  assign in_i.ready = (state_q == cpst_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign head_match = (head_i.hi == key_q) || (head_i.lo == key_q);
  assign drop       = (cmd_q == cpst_pkg::CMD_REMOVE) && head_match;
  assign count_m1   = count_q - 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpst_pkg::ST_IDLE: begin
        if (accept) begin
          if (((in_cmd == cpst_pkg::CMD_REMOVE) || (in_cmd == cpst_pkg::CMD_FIND)) &&
              (count_q != '0)) begin
            state_d = cpst_pkg::ST_SCAN;
          end else begin
            state_d = cpst_pkg::ST_DONE;
          end
        end
      end
      cpst_pkg::ST_SCAN: begin
        if (step_q == cpst_pkg::CNT_W'(1)) begin
          state_d = cpst_pkg::ST_DONE;
        end
      end
      cpst_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = cpst_pkg::ST_IDLE;
        end
      end
      default: state_d = cpst_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath. During a scan the head pair leaves the chain each
  // cycle and is written back at the tail unless a remove drops it, so one
  // full rotation keeps the surviving pairs in their original order.
  always_comb begin
    count_d       = count_q;
    step_d        = step_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    partner_d     = partner_q;
    found_d       = found_q;
    full_d        = full_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_partner_d = out_partner_q;
    out_found_d   = out_found_q;
    out_full_d    = out_full_q;
    out_entries_d = out_entries_q;
    cell_ctrl_o   = '0;

    unique case (state_q)
      cpst_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d     = in_cmd;
          key_d     = in_i.key_a;
          step_d    = count_q;
          partner_d = cpst_pkg::NO_PARTNER;
          found_d   = 1'b0;
          full_d    = 1'b0;
          if (in_cmd == cpst_pkg::CMD_ADD) begin
            if (count_q < cpst_pkg::CNT_W'(cpst_pkg::NUM_PAIRS)) begin
              cell_ctrl_o.wr_en   = 1'b1;
              cell_ctrl_o.wr_idx  = count_q[cpst_pkg::IDX_W-1:0];
              cell_ctrl_o.wr_data = '{hi: in_i.key_a, lo: in_i.key_b};
              count_d             = count_q + 1'b1;
            end else begin
              full_d = 1'b1;
            end
          end
        end
      end
      cpst_pkg::ST_SCAN: begin
        cell_ctrl_o.shift   = 1'b1;
        cell_ctrl_o.wr_en   = !drop;
        cell_ctrl_o.wr_idx  = count_m1[cpst_pkg::IDX_W-1:0];
        cell_ctrl_o.wr_data = head_i;
        step_d              = step_q - 1'b1;
        if (drop) begin
          count_d = count_m1;
        end
        if ((cmd_q == cpst_pkg::CMD_FIND) && !found_q && head_match) begin
          found_d   = 1'b1;
          partner_d = (head_i.hi == key_q) ? head_i.lo : head_i.hi;
        end
      end
      cpst_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_partner_d = partner_q;
          out_found_d   = found_q;
          out_full_d    = full_q;
          out_entries_d = cpst_pkg::to_entries(count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpst_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q        <= step_d;
    cmd_q         <= cmd_d;
    key_q         <= key_d;
    partner_q     <= partner_d;
    found_q       <= found_d;
    full_q        <= full_d;
    out_partner_q <= out_partner_d;
    out_found_q   <= out_found_d;
    out_full_q    <= out_full_d;
    out_entries_q <= out_entries_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.partner        = out_partner_q;
  assign out_o.found          = out_found_q;
  assign out_o.full_error     = out_full_q;
  assign out_o.entries_in_use = out_entries_q;

  assign status_o.scanning = (state_q == cpst_pkg::ST_SCAN);
  assign status_o.count    = count_q;

endmodule

>>> tb/cpst_reply_checker.sv
// Watches the command and result channels of the pair swap table and predicts every reply.
// It compares each reply field by field and reports the counts to the testbench top.
// Depends on cpst_pkg and the channel interfaces in cpst_if.sv.
module cpst_reply_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cpst_in_if   cmd_i,
  cpst_out_if  res_i,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o,
  output int   hits_o,
  output int   drops_o
);
  import cpst_pkg::*;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [7:0]           partner;
    logic                 found;
    logic                 full_error;
    logic [ENTRIES_W-1:0] entries;
  } table_reply_t;

  pair_t        pairs [NUM_PAIRS];
  int unsigned  npairs;
  table_reply_t want_replies [$];
  int           fails;
  int           checked;
  int           hits;
  int           drops;

  initial begin
    fails   = 0;
    checked = 0;
    hits    = 0;
    drops   = 0;
    npairs  = 0;
  end

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    fails++;
    if (fails <= PRINT_CAP) begin
      $display("MISMATCH reply %0d: %s got %0h, want %0h", checked, what, got, want);
    end
  endtask

  // Applies one command to the shadow table and returns the reply it should produce.
  function automatic table_reply_t table_apply(cmd_e op, logic [7:0] key, logic [7:0] second);
    table_reply_t r;
    int unsigned  keep;
    bit           hit;
    r.partner    = NO_PARTNER;
    r.found      = 1'b0;
    r.full_error = 1'b0;
    case (op)
      CMD_ADD: begin
        if (npairs < NUM_PAIRS) begin
          pairs[npairs] = '{hi: key, lo: second};
          npairs++;
        end else begin
          r.full_error = 1'b1;
        end
      end
      CMD_REMOVE: begin
        keep = 0;
        for (int i = 0; i < npairs; i++) begin
          if (pairs[i].hi != key && pairs[i].lo != key) begin
            pairs[keep] = pairs[i];
            keep++;
          end
        end
        npairs = keep;
      end
      CMD_FIND: begin
        hit = 1'b0;
        // The first byte of a pair is tested before its second byte.
        for (int i = 0; i < npairs && !hit; i++) begin
          if (pairs[i].hi == key) begin
            r.partner = pairs[i].lo;
            hit = 1'b1;
          end else if (pairs[i].lo == key) begin
            r.partner = pairs[i].hi;
            hit = 1'b1;
          end
        end
        r.found = hit;
      end
      default: begin
      end
    endcase
    r.entries = ENTRIES_W'(npairs);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t want;
    if (!rst_ni) begin
      npairs = 0;
      want_replies.delete();
    end else begin
      // Push before pop so that a same-edge reply still finds its expectation.
      if (cmd_i.valid && cmd_i.ready) begin
        want_replies.push_back(table_apply(cmd_e'(cmd_i.cmd), cmd_i.key_a, cmd_i.key_b));
      end
      if (res_i.valid && res_i.ready) begin
        if (want_replies.size() == 0) begin
          report("reply with no command outstanding, partner", res_i.partner, 8'h00);
        end else begin
          want = want_replies.pop_front();
          if (res_i.partner !== want.partner) begin
            report("partner", res_i.partner, want.partner);
          end
          if (res_i.found !== want.found) begin
            report("found", 8'(res_i.found), 8'(want.found));
          end
          if (res_i.full_error !== want.full_error) begin
            report("full_error", 8'(res_i.full_error), 8'(want.full_error));
          end
          if (res_i.entries_in_use !== want.entries) begin
            report("entries_in_use", 8'(res_i.entries_in_use), 8'(want.entries));
          end
          if (want.found) hits++;
          if (want.full_error) drops++;
          checked++;
        end
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= want_replies.size();
    checked_o  <= checked;
    hits_o     <= hits;
    drops_o    <= drops;
  end

endmodule

>>> tb/tb_char_pair_swap_table.sv
// Testbench top for the pair swap table: clock, reset, command stimulus and result back-pressure.
// Depends on cpst_pkg, the channel interfaces, the DUT and cpst_reply_checker.
module tb_char_pair_swap_table;
  import cpst_pkg::*;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int STALL_LEN       = 400;
  localparam int DRAIN_CYCLES    = NUM_PAIRS + 20;
  localparam int ITEMS_PER_PHASE = 610;

  logic clk;
  logic rst_n;
  int   snd_idle;
  int   rcv_idle;
  bit   stall_req;
  int   cycles;
  int   sent_by_cmd [4];

  int fail_cnt;
  int pending;
  int checked;
  int hits;
  int drops;

  cpst_in_if  cmd_ch ();
  cpst_out_if res_ch ();

  char_pair_swap_table DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  cpst_reply_checker table_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_i      (cmd_ch),
    .res_i      (res_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked),
    .hits_o     (hits),
    .drops_o    (drops)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d replies outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off whenever stall_req toggles.
  initial begin : res_sink
    int stall_left;
    bit stall_seen;
    res_ch.ready = 1'b0;
    stall_left   = 0;
    stall_seen   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        stall_left = STALL_LEN;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Keys lean on a narrow pool so that finds and removes hit stored pairs often.
  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 8'($urandom_range(0, 15));
    if (r < 58) return 8'hFF;
    if (r < 62) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_cmd(cmd_e op, logic [7:0] a, logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= op;
    cmd_ch.key_a <= a;
    cmd_ch.key_b <= b;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent_by_cmd[int'(op)]++;
  endtask

  // One random phase: overfill the table first, then alternate growing and shrinking runs.
  task automatic run_phase(int snd_pct, int rcv_pct, bit with_stall, int n_items);
    int   done;
    int   mode_left;
    bit   grow;
    int   r;
    cmd_e op;
    snd_idle  = snd_pct;
    rcv_idle <= rcv_pct;
    if (with_stall) stall_req <= ~stall_req;
    done      = 0;
    mode_left = 0;
    grow      = 1'b0;
    for (int i = 0; i < NUM_PAIRS + 3; i++) begin
      send_cmd(CMD_ADD, pick_key(), pick_key());
      done++;
    end
    while (done < n_items) begin
      if (mode_left == 0) begin
        grow      = !grow;
        mode_left = $urandom_range(20, 60);
      end
      r = $urandom_range(99);
      if (grow) begin
        op = (r < 65) ? CMD_ADD : (r < 72) ? CMD_REMOVE : (r < 96) ? CMD_FIND : CMD_NOP;
      end else begin
        op = (r < 25) ? CMD_ADD : (r < 50) ? CMD_REMOVE : (r < 95) ? CMD_FIND : CMD_NOP;
      end
      send_cmd(op, pick_key(), 8'($urandom_range(0, 255)));
      done++;
      mode_left--;
    end
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd   = CMD_NOP;
    cmd_ch.key_a = 8'h00;
    cmd_ch.key_b = 8'h00;
    rst_n        = 1'b0;
    snd_idle     = 0;
    rcv_idle     = 0;
    stall_req    = 1'b0;
    foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, both match positions, doubled byte, misses, no-op.
    snd_idle  = 12;
    rcv_idle <= 70;
    send_cmd(CMD_FIND,   8'h41, 8'h00);
    send_cmd(CMD_REMOVE, 8'h41, 8'hFF);
    send_cmd(CMD_NOP,    8'hFF, 8'hFF);
    send_cmd(CMD_ADD,    8'h00, 8'hFF);
    send_cmd(CMD_ADD,    8'hFF, 8'h00);
    send_cmd(CMD_ADD,    8'h5A, 8'h5A);
    send_cmd(CMD_ADD,    8'hA5, 8'h00);
    send_cmd(CMD_FIND,   8'h00, 8'h55);
    send_cmd(CMD_FIND,   8'hFF, 8'hAA);
    send_cmd(CMD_FIND,   8'h5A, 8'h00);
    send_cmd(CMD_FIND,   8'hA5, 8'hFF);
    send_cmd(CMD_FIND,   8'h11, 8'h00);
    send_cmd(CMD_REMOVE, 8'h77, 8'hFF);
    send_cmd(CMD_REMOVE, 8'h00, 8'h00);
    send_cmd(CMD_FIND,   8'h00, 8'h00);
    send_cmd(CMD_FIND,   8'h5A, 8'hFF);
    send_cmd(CMD_ADD,    8'h80, 8'h01);
    send_cmd(CMD_ADD,    8'h01, 8'h80);
    send_cmd(CMD_FIND,   8'h80, 8'h00);
    send_cmd(CMD_REMOVE, 8'h5A, 8'h00);
    send_cmd(CMD_FIND,   8'h01, 8'h00);
    send_cmd(CMD_NOP,    8'h00, 8'h00);
    send_cmd(CMD_REMOVE, 8'h80, 8'hFF);
    send_cmd(CMD_FIND,   8'h80, 8'hFF);
    send_cmd(CMD_ADD,    8'hFF, 8'hFF);
    send_cmd(CMD_REMOVE, 8'hFF, 8'h00);

    run_phase(12, 70, 1'b1, ITEMS_PER_PHASE);
    run_phase(70, 12, 1'b0, ITEMS_PER_PHASE);
    run_phase(0,  0,  1'b1, ITEMS_PER_PHASE);
    cmd_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d adds, %0d removes, %0d finds and %0d no-ops under three idle mixes.",
             sent_by_cmd[int'(CMD_ADD)], sent_by_cmd[int'(CMD_REMOVE)],
             sent_by_cmd[int'(CMD_FIND)], sent_by_cmd[int'(CMD_NOP)]);
    $display("Checked %0d replies: %0d find hits, %0d adds dropped on a full table.",
             checked, hits, drops);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
